// ----- src/gcmp_pkg.sv -----
package gcmp_pkg;

  localparam int unsigned NumColors = 4;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned SegSpan   = 85;
  localparam int unsigned ValW      = 8;
  localparam int unsigned FracW     = 16;
  localparam int unsigned LevelW    = FracW + 1;
  localparam int unsigned ProdW     = LevelW + FracW;

  localparam logic [LevelW-1:0] QOne   = LevelW'(65536);
  localparam logic [LevelW-1:0] QFifth = LevelW'(13107);

  localparam logic [ValW-1:0] ValMax  = ValW'(255);
  localparam logic [ValW-1:0] SegTwo  = ValW'(2 * SegSpan);
  localparam logic [ValW-1:0] SegOne  = ValW'(SegSpan);

  typedef logic [1:0]        stop_idx_t;
  typedef logic [ValW-1:0]   val_t;
  typedef logic [FracW-1:0]  frac_t;
  typedef logic [LevelW-1:0] level_t;

  typedef logic [LevelW-1:0] stop_row_t [NumChan];
  typedef stop_row_t         stop_tbl_t [NumColors];
  typedef logic [FracW-1:0]  frac_tbl_t [256];

  localparam stop_tbl_t Stops = '{
    '{LevelW'(0), LevelW'(0), LevelW'(0)},
    '{QOne, QFifth, QFifth},
    '{QOne, QOne, QFifth},
    '{QOne, QOne, QOne}
  };

  function automatic frac_tbl_t build_frac();
    frac_tbl_t   tbl;
    int unsigned rem;
    for (int unsigned i = 0; i < 256; i++) begin
      rem    = i % SegSpan;
      tbl[i] = FracW'((rem << FracW) / SegSpan);
    end
    return tbl;
  endfunction

  localparam frac_tbl_t FracTbl = build_frac();

  typedef struct packed {
    val_t                        value;
    frac_t                       frac;
    logic [NumChan-1:0][LevelW-1:0] lo;
    logic [NumChan-1:0][LevelW-1:0] diff;
  } seg_t;

endpackage

// ----- src/gcmp_lookup.sv -----
module gcmp_lookup (
  input  logic            clk_i,
  input  logic            en_i,
  input  gcmp_pkg::val_t  value_i,
  output gcmp_pkg::seg_t  seg_o
);
  import gcmp_pkg::*;

  seg_t      seg_d, seg_q;
  stop_idx_t lo_idx, hi_idx;

  always_comb begin
    if (value_i == '0) begin
      lo_idx = 2'd0;
      hi_idx = 2'd0;
    end else if (value_i == ValMax) begin
      lo_idx = 2'd3;
      hi_idx = 2'd3;
    end else if (value_i >= SegTwo) begin
      lo_idx = 2'd2;
      hi_idx = 2'd3;
    end else if (value_i >= SegOne) begin
      lo_idx = 2'd1;
      hi_idx = 2'd2;
    end else begin
      lo_idx = 2'd0;
      hi_idx = 2'd1;
    end
  end

  always_comb begin
    seg_d.value = value_i;
    if ((value_i == '0) || (value_i == ValMax)) begin
      seg_d.frac = '0;
    end else begin
      seg_d.frac = FracTbl[value_i];
    end
    for (int c = 0; c < NumChan; c++) begin
      seg_d.lo[c]   = Stops[lo_idx][c];
      seg_d.diff[c] = Stops[hi_idx][c] - Stops[lo_idx][c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q <= seg_d;
    end
  end

  assign seg_o = seg_q;

endmodule

// ----- src/gcmp_channel.sv -----
module gcmp_channel (
  input  logic              clk_i,
  input  gcmp_pkg::val_t    value_i,
  input  gcmp_pkg::frac_t   frac_i,
  input  gcmp_pkg::level_t  lo_i,
  input  gcmp_pkg::level_t  diff_i,
  output gcmp_pkg::val_t    chan_o
);
  import gcmp_pkg::*;

  logic [ProdW-1:0]      prod_q;
  level_t                lo_q;
  val_t                  v2_q;
  logic [LevelW:0]       sum;
  level_t                level_d, level_q;
  val_t                  v3_q;
  logic [LevelW+ValW-1:0] scaled;
  val_t                  chan_q;

  // interp product
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(diff_i) * ProdW'(frac_i);
    lo_q   <= lo_i;
    v2_q   <= value_i;
  end

  // level with clamp
  always_comb begin
    sum = {1'b0, lo_q} + (LevelW + 1)'(prod_q[ProdW-1:FracW]);
    if (sum > (LevelW + 1)'(QOne)) begin
      level_d = QOne;
    end else begin
      level_d = sum[LevelW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    v3_q    <= v2_q;
  end

  // scale by intensity
  assign scaled = (LevelW + ValW)'(v3_q) * (LevelW + ValW)'(level_q);

  always_ff @(posedge clk_i) begin
    chan_q <= scaled[FracW+ValW-1:FracW];
  end

  assign chan_o = chan_q;

endmodule

// ----- src/gradient_colormap_pixel.sv -----
// An accepted start passes through the lookup, product, level, scale and output
//   stages before valid_o.
// Throughput: one word per cycle; busy is tied low, the result path has no stall.
// Reset: rst_ni clears the valid pipeline only; data registers are not reset.
// Results are shown for one cycle; the receiver cannot hold them off.
module gradient_colormap_pixel (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  logic [7:0]     value_i,
  output logic           valid_o,
  output logic [7:0]     red_o,
  output logic [7:0]     green_o,
  output logic [7:0]     blue_o,
  output logic [7:0]     alpha_o
);
  import gcmp_pkg::*;

  localparam int unsigned Depth = 4;

  logic              accept;
  logic [Depth-1:0]  vld_d, vld_q;
  seg_t              seg;
  val_t              chan [NumChan];
  val_t              alpha_d [Depth-1];
  val_t              alpha_q [Depth-1];
  logic              out_vld_q;
  val_t              red_q, green_q, blue_q, out_alpha_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  gcmp_lookup u_lookup (
    .clk_i   (clk_i),
    .en_i    (accept),
    .value_i (value_i),
    .seg_o   (seg)
  );

  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    gcmp_channel u_chan (
      .clk_i   (clk_i),
      .value_i (seg.value),
      .frac_i  (seg.frac),
      .lo_i    (seg.lo[c]),
      .diff_i  (seg.diff[c]),
      .chan_o  (chan[c])
    );
  end

  always_comb begin
    vld_d = {vld_q[Depth-2:0], accept};
    alpha_d[0] = seg.value;
    for (int i = 1; i < Depth - 1; i++) begin
      alpha_d[i] = alpha_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_q     <= alpha_d;
    red_q       <= chan[0];
    green_q     <= chan[1];
    blue_q      <= chan[2];
    out_alpha_q <= alpha_q[Depth-2];
  end

  assign valid_o = out_vld_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign alpha_o = out_alpha_q;

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, Depth + 1))
    else $error("result without matching start");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (alpha_o == $past(value_i, Depth + 1)))
    else $error("alpha does not follow input");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (alpha_o == '0)) |-> ((red_o == '0) && (green_o == '0) && (blue_o == '0)))
    else $error("zero intensity not black");

  a_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (alpha_o == ValMax)) |->
      ((red_o == ValMax) && (green_o == ValMax) && (blue_o == ValMax)))
    else $error("full intensity not white");

endmodule
